// File: src/zdt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zdt_pkg
// Shared types and constants of the zone dwell trigger: register indexes,
// zone box layout and the records passed between the front, queue and back.
// ----------------------------------------------------------------------------
package zdt_pkg;

  localparam int NUM_ZONES_DEF = 4;
  localparam int BOX_REGS      = 4;
  localparam int FIFO_DEPTH    = 2;
  localparam int ZONE_W        = 2;
  localparam int COORD_W       = 16;
  localparam int TIME_W        = 32;
  localparam int DWELL_W       = 16;
  localparam int COUNT_W       = 3;
  localparam int BOX_W         = 64;
  localparam int CFG_IDX_W     = 3;

  localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd1000;

  localparam logic [CFG_IDX_W-1:0] CFG_ZONE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_BASE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL      = 3'd5;

  // Classified detection, written by the front into the queue.
  typedef struct packed {
    logic              hit;
    logic [ZONE_W-1:0] zone;
    logic [TIME_W-1:0] time_ms;
  } cls_t;

  // One result transaction.
  typedef struct packed {
    logic              tracking;
    logic [ZONE_W-1:0] zone_id;
    logic              trigger;
  } res_t;

endpackage

// File: src/zdt_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zdt_front
// Classifies one detection: finds the lowest-numbered active zone whose box
// contains the point, in parallel over all zones.
// ----------------------------------------------------------------------------
module zdt_front #(
  parameter int NUM_ZONES = zdt_pkg::NUM_ZONES_DEF
) (
  input  logic                                    present,
  input  logic signed [zdt_pkg::COORD_W-1:0]      pos_x,
  input  logic signed [zdt_pkg::COORD_W-1:0]      pos_y,
  input  logic [zdt_pkg::TIME_W-1:0]              time_ms,
  input  logic [zdt_pkg::COUNT_W-1:0]             zone_count,
  input  logic [NUM_ZONES-1:0][zdt_pkg::BOX_W-1:0] boxes,
  output zdt_pkg::cls_t                           cls
);

  logic [NUM_ZONES-1:0] match;

  always_comb begin
    logic signed [zdt_pkg::COORD_W:0]   dx;
    logic signed [zdt_pkg::COORD_W:0]   dy;
    logic        [zdt_pkg::COORD_W:0]   ax;
    logic        [zdt_pkg::COORD_W:0]   ay;
    logic signed [zdt_pkg::COORD_W+1:0] hw;
    logic signed [zdt_pkg::COORD_W+1:0] hh;
    for (int i = 0; i < NUM_ZONES; i++) begin
      dx = $signed({pos_x[15], pos_x}) - $signed({boxes[i][15], boxes[i][15:0]});
      dy = $signed({pos_y[15], pos_y}) - $signed({boxes[i][31], boxes[i][31:16]});
      ax = dx[zdt_pkg::COORD_W] ? 17'(-dx) : 17'(dx);
      ay = dy[zdt_pkg::COORD_W] ? 17'(-dy) : 17'(dy);
      hw = $signed({{2{boxes[i][47]}}, boxes[i][47:32]});
      hh = $signed({{2{boxes[i][63]}}, boxes[i][63:48]});
      match[i] = (zone_count > zdt_pkg::COUNT_W'(i)) &&
                 ($signed({1'b0, ax}) <= hw) && ($signed({1'b0, ay}) <= hh);
    end
  end

  always_comb begin
    cls.hit     = 1'b0;
    cls.zone    = '0;
    cls.time_ms = time_ms;
    for (int i = NUM_ZONES - 1; i >= 0; i--) begin
      if (match[i]) begin
        cls.hit  = present;
        cls.zone = zdt_pkg::ZONE_W'(i);
      end
    end
  end

endmodule

// File: src/zdt_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zdt_fifo
// Short queue of classified detections between the front and the back.
// ----------------------------------------------------------------------------
module zdt_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  zdt_pkg::cls_t wr_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output zdt_pkg::cls_t rd_data
);

  localparam int DEPTH = zdt_pkg::FIFO_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  zdt_pkg::cls_t    mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign rd_data   = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not follow a push");

endmodule

// File: src/zdt_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zdt_back
// Tracking state machine: updates the tracked zone and entry time for each
// classified detection and holds the result in an output register.
// ----------------------------------------------------------------------------
module zdt_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         q_valid,
  input  zdt_pkg::cls_t                q_data,
  output logic                         q_pop,
  input  logic [zdt_pkg::DWELL_W-1:0]  dwell_ms,
  output logic                         res_valid,
  input  logic                         res_ready,
  output zdt_pkg::res_t                res
);

  logic                        tv_r;
  logic                        tv_nxt;
  logic [zdt_pkg::ZONE_W-1:0]  tz_r;
  logic [zdt_pkg::ZONE_W-1:0]  tz_nxt;
  logic [zdt_pkg::TIME_W-1:0]  et_r;
  logic [zdt_pkg::TIME_W-1:0]  et_nxt;
  logic                        valid_r;
  zdt_pkg::res_t               res_r;
  zdt_pkg::res_t               res_nxt;
  logic [zdt_pkg::TIME_W-1:0]  elapsed;

  assign q_pop     = q_valid && (!valid_r || res_ready);
  assign res_valid = valid_r;
  assign res       = res_r;
  assign elapsed   = q_data.time_ms - et_r;

  always_comb begin
    tv_nxt          = tv_r;
    tz_nxt          = tz_r;
    et_nxt          = et_r;
    res_nxt.trigger = 1'b0;
    if (!q_data.hit) begin
      tv_nxt = 1'b0;
      tz_nxt = '0;
    end else if (!tv_r || (tz_r != q_data.zone)) begin
      tv_nxt = 1'b1;
      tz_nxt = q_data.zone;
      et_nxt = q_data.time_ms;
    end else if (elapsed >= {16'd0, dwell_ms}) begin
      res_nxt.trigger = 1'b1;
      tv_nxt          = 1'b0;
      tz_nxt          = '0;
    end
    res_nxt.tracking = tv_nxt;
    res_nxt.zone_id  = res_nxt.trigger ? q_data.zone : (tv_nxt ? tz_nxt : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r    <= 1'b0;
      tz_r    <= '0;
      et_r    <= '0;
      valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        tv_r    <= tv_nxt;
        tz_r    <= tz_nxt;
        et_r    <= et_nxt;
        valid_r <= 1'b1;
      end else if (res_ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  a_idle_zone: assert property (@(posedge clk) disable iff (!rst_n)
    !tv_r |-> (tz_r == '0))
    else $error("tracked zone not cleared while idle");

  a_trig_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && res_nxt.trigger) |=> (!tv_r && valid_r && !res_r.tracking))
    else $error("trigger did not clear tracking");

endmodule

// File: src/zone_dwell_trigger.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zone_dwell_trigger
// Region-of-interest dwell detector: raises a trigger once a detection has
// stayed in one rectangular zone for the programmed dwell time.
//
//   Channel  Direction  Handshake          Payload
//   in_      slave      tvalid / tready    tuser: present; tdata: x, y, time
//   out_     master     tvalid / tready    tdata: trigger, zone_id, tracking
//   cfg_     slave      valid / ready      index, 64-bit data
//
// One transaction per cycle is sustained while out_tready is high; a result
// passes through the queue write and the output register of the back end.
// The front classifies all zones in parallel in the accepting cycle.
// Reset is synchronous and needs no clearing pass; cfg_ready is always high.
// A stalled output fills the two-entry queue, after which in_tready drops.
// ----------------------------------------------------------------------------
module zone_dwell_trigger #(
  parameter int NUM_ZONES = zdt_pkg::NUM_ZONES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [15:0] pos_x, [31:16] pos_y, [63:32] time_ms
  input  logic [63:0]                     in_tdata,
  // [0] present
  input  logic                            in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] trigger, [2:1] zone_id, [3] tracking, [7:4] zero
  output logic [7:0]                      out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [zdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [zdt_pkg::BOX_W-1:0]       cfg_data
);

  localparam int ZONES_USED = (NUM_ZONES < zdt_pkg::BOX_REGS) ? NUM_ZONES
                                                              : zdt_pkg::BOX_REGS;

  logic [zdt_pkg::COUNT_W-1:0]              zone_count_r;
  logic [ZONES_USED-1:0][zdt_pkg::BOX_W-1:0] box_r;
  logic [zdt_pkg::DWELL_W-1:0]              dwell_r;
  zdt_pkg::cls_t                            cls;
  zdt_pkg::cls_t                            q_data;
  zdt_pkg::res_t                            res;
  logic                                     q_full;
  logic                                     q_valid;
  logic                                     q_pop;
  logic                                     in_acc;

  assign cfg_ready = 1'b1;
  assign in_tready = !q_full;
  assign in_acc    = in_tvalid && !q_full;
  assign out_tdata = {4'd0, res};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_count_r <= '0;
      box_r        <= '0;
      dwell_r      <= zdt_pkg::DWELL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        zdt_pkg::CFG_ZONE_COUNT: begin
          zone_count_r <= cfg_data[zdt_pkg::COUNT_W-1:0];
        end
        zdt_pkg::CFG_DWELL: begin
          dwell_r <= cfg_data[zdt_pkg::DWELL_W-1:0];
        end
        default: begin
          for (int i = 0; i < ZONES_USED; i++) begin
            if (cfg_index == zdt_pkg::CFG_BOX_BASE + zdt_pkg::CFG_IDX_W'(i)) begin
              box_r[i] <= cfg_data;
            end
          end
        end
      endcase
    end
  end

  zdt_front #(
    .NUM_ZONES (ZONES_USED)
  ) u_front (
    .present    (in_tuser),
    .pos_x      (in_tdata[15:0]),
    .pos_y      (in_tdata[31:16]),
    .time_ms    (in_tdata[63:32]),
    .zone_count (zone_count_r),
    .boxes      (box_r),
    .cls        (cls)
  );

  zdt_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_acc),
    .wr_data   (cls),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_data   (q_data)
  );

  zdt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .dwell_ms  (dwell_r),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

endmodule
